@@ rtl/contact_spring_force_macros.svh @@
// Assertion macros for the contact spring force block.
// Included by the top level; no other dependencies.
`ifndef CONTACT_SPRING_FORCE_MACROS_SVH
`define CONTACT_SPRING_FORCE_MACROS_SVH

// same-cycle implication
`define CSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cfsf_pkg.sv @@
// Shared constants and types for the contact spring force block.
// No dependencies.
package cfsf_pkg;

   localparam int DIV_STEPS  = 34;
   localparam int DIV_DEN_W  = 33;
   localparam int DIV_NUM_W  = DIV_STEPS + DIV_DEN_W;
   localparam int DIV_REM_W  = DIV_DEN_W + 1;

   localparam int SQRT_STEPS = 32;
   localparam int SQRT_IN_W  = 2 * SQRT_STEPS;
   localparam int SQRT_REM_W = SQRT_STEPS + 3;

   localparam int ALIGN_LAT  = DIV_STEPS - SQRT_STEPS;
   // stage A, B, div, C, div, D, E, F, G, div, H, I
   localparam int PIPE_LAT   = 9 + 3 * DIV_STEPS;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPRING_CONSTANT = 1'b0,
      CSR_DAMPING_FACTOR  = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] SPRING_RESET  = 32'h0001_0000;
   localparam logic [CSR_DATA_W-1:0] DAMPING_RESET = 32'h0001_0000;

   localparam logic [DIV_STEPS-1:0] ACC_CAP = 34'h1_FFFF_FFFF;

endpackage

@@ rtl/cfsf_req_if.sv @@
// Input channel of the contact spring force block: one particle pair per transfer.
// No dependencies.
interface cfsf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] rel_pos_x;
   logic signed [31:0] rel_pos_y;
   logic signed [31:0] rel_pos_z;
   logic signed [31:0] rel_vel_x;
   logic signed [31:0] rel_vel_y;
   logic signed [31:0] rel_vel_z;
   logic        [31:0] mass_i;
   logic        [31:0] mass_j;
   logic        [30:0] radius_i;
   logic        [30:0] radius_j;

   modport source (
      output valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
      output mass_i, mass_j, radius_i, radius_j,
      input  ready
   );
   modport sink (
      input  valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
      input  mass_i, mass_j, radius_i, radius_j,
      output ready
   );
endinterface

@@ rtl/cfsf_rsp_if.sv @@
// Result channel of the contact spring force block: accelerations of both particles.
// No dependencies.
interface cfsf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_i_x;
   logic signed [31:0] accel_i_y;
   logic signed [31:0] accel_i_z;
   logic signed [31:0] accel_j_x;
   logic signed [31:0] accel_j_y;
   logic signed [31:0] accel_j_z;
   logic               in_contact;

   modport source (
      output valid, accel_i_x, accel_i_y, accel_i_z, accel_j_x, accel_j_y, accel_j_z,
      output in_contact,
      input  ready
   );
   modport sink (
      input  valid, accel_i_x, accel_i_y, accel_i_z, accel_j_x, accel_j_y, accel_j_z,
      input  in_contact,
      output ready
   );
endinterface

@@ rtl/contact_spring_force.sv @@
// Top level of the damped linear spring contact force pipeline.
// Depends on cfsf_pkg, cfsf_req_if, cfsf_rsp_if, cfsf_sqrt, cfsf_div and the macro header.
//
//   port   | direction | carries
//   req    | in        | relative position and velocity, masses, radii of one pair
//   rsp    | out       | accelerations of both particles, contact flag
//   csr_*  | in        | spring constant and damping factor writes
//
// One pair per cycle while finished results are taken; three chained 34-step divider sections
// (distance/reduced mass, unit normal/damping root, scalar acceleration) form the pipeline core.
// Reset clears all valid bits and loads both registers with 1.0.
// When a finished result is not taken the whole pipeline holds, so req.ready drops.
`include "contact_spring_force_macros.svh"

module contact_spring_force
   import cfsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cfsf_req_if.sink              req,
   cfsf_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      logic [2:0][31:0] rp;
      logic [2:0][31:0] rv;
      logic [31:0]      mi;
      logic [31:0]      mj;
      logic [31:0]      rsum;
   } side_a_type;

   typedef struct packed {
      logic [2:0][31:0] rv;
      logic [31:0]      mi;
      logic [31:0]      mj;
      logic             contact;
      logic             live;
      logic [31:0]      overlap;
      logic [2:0]       rp_neg;
   } side_c_type;

   typedef struct packed {
      logic [31:0]      mi;
      logic [31:0]      mj;
      logic             contact;
      logic             live;
      logic [2:0][30:0] nrm_mag;
      logic [2:0]       rp_neg;
   } side_d_type;

   typedef struct packed {
      logic             contact;
      logic             live;
      logic [2:0][30:0] nrm_mag;
      logic [2:0]       rp_neg;
      logic             f_neg;
      logic             sat_i;
      logic             sat_j;
   } side_g_type;

   typedef struct packed {
      logic       contact;
      logic       live;
      logic [2:0] neg_i;
   } side_h_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic logic [31:0] sat_out(input logic [33:0] mag, input logic neg);
      logic [33:0] lim;
      logic [33:0] m;
      lim = neg ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
      m   = (mag > lim) ? lim : mag;
      return neg ? (32'd0 - m[31:0]) : m[31:0];
   endfunction

   // ---------------- control ----------------
   logic                  en;
   logic [PIPE_LAT-1:0]   vld_ff;
   logic [PIPE_LAT-1:0]   vld_in;
   logic [CSR_DATA_W-1:0] spring_ff;
   logic [CSR_DATA_W-1:0] damping_ff;

   assign en        = !vld_ff[PIPE_LAT-1] || rsp.ready;
   assign req.ready = en;
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spring_ff  <= SPRING_RESET;
         damping_ff <= DAMPING_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPRING_CONSTANT: spring_ff  <= csr_wdata;
            CSR_DAMPING_FACTOR:  damping_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage A: squares, mass product ----------------
   logic [2:0][31:0] a_mag;
   logic [63:0]      a_sq_ff    [3];
   logic [63:0]      a_sq_in    [3];
   logic [63:0]      a_mprod_ff, a_mprod_in;
   logic [32:0]      a_msum_ff, a_msum_in;
   side_a_type       a_side_ff, a_side_in;

   always_comb begin
      a_side_in.rp   = {req.rel_pos_z, req.rel_pos_y, req.rel_pos_x};
      a_side_in.rv   = {req.rel_vel_z, req.rel_vel_y, req.rel_vel_x};
      a_side_in.mi   = req.mass_i;
      a_side_in.mj   = req.mass_j;
      a_side_in.rsum = 32'(req.radius_i) + 32'(req.radius_j);
      for (int k = 0; k < 3; k++) begin
         a_mag[k]   = mag32(a_side_in.rp[k]);
         a_sq_in[k] = 64'(a_mag[k]) * 64'(a_mag[k]);
      end
      a_mprod_in = 64'(req.mass_i) * 64'(req.mass_j);
      a_msum_in  = 33'(req.mass_i) + 33'(req.mass_j);
   end

   // ---------------- stage B: sum of squares ----------------
   logic [63:0] b_sq_ff, b_sq_in;
   logic [63:0] b_mprod_ff, b_mprod_in;
   logic [32:0] b_mden_ff, b_mden_in;
   side_a_type  b_side_ff, b_side_in;

   always_comb begin
      b_sq_in    = a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];
      b_mprod_in = a_mprod_ff;
      // a zero mass sum comes with a zero product, so dividing by one gives zero
      b_mden_in  = {a_msum_ff[32:1], a_msum_ff[0] | (a_msum_ff == '0)};
      b_side_in  = a_side_ff;
   end

   // ---------------- section 2: distance and reduced mass ----------------
   logic [SQRT_STEPS-1:0] dist_root;
   logic [DIV_STEPS-1:0]  mij_quot;
   logic [31:0]           p2_dist_ff [ALIGN_LAT];
   side_a_type            p2_side_ff [DIV_STEPS];

   cfsf_sqrt u_sqrt_dist (
      .clock    (clock),
      .en       (en),
      .radicand (b_sq_ff),
      .root     (dist_root)
   );

   cfsf_div u_div_mij (
      .clock (clock),
      .en    (en),
      .numer ({3'b000, b_mprod_ff}),
      .denom (b_mden_ff),
      .quot  (mij_quot)
   );

   // ---------------- stage C: overlap, normal numerators ----------------
   logic [31:0]          c_dist;
   side_a_type           c_sa;
   logic [63:0]          c_mdf_ff, c_mdf_in;
   logic [DIV_NUM_W-1:0] c_num_ff [3];
   logic [DIV_NUM_W-1:0] c_num_in [3];
   logic [DIV_DEN_W-1:0] c_den_ff, c_den_in;
   side_c_type           c_side_ff, c_side_in;

   always_comb begin
      c_dist = p2_dist_ff[ALIGN_LAT-1];
      c_sa   = p2_side_ff[DIV_STEPS-1];
      c_mdf_in = 64'(mij_quot[31:0]) * 64'(damping_ff);
      for (int k = 0; k < 3; k++) begin
         c_num_in[k]         = {5'b00000, mag32(c_sa.rp[k]), 30'd0};
         c_side_in.rp_neg[k] = c_sa.rp[k][31];
      end
      c_den_in          = {1'b0, c_dist[31:1], c_dist[0] | (c_dist == '0)};
      c_side_in.rv      = c_sa.rv;
      c_side_in.mi      = c_sa.mi;
      c_side_in.mj      = c_sa.mj;
      c_side_in.contact = c_sa.rsum > c_dist;
      // coincident centres: contact but no normal
      c_side_in.live    = (c_sa.rsum > c_dist) && (c_dist != '0);
      c_side_in.overlap = c_sa.rsum - c_dist;
   end

   // ---------------- section 4: unit normal, damping coefficient ----------------
   logic [DIV_STEPS-1:0]  nrm_quot [3];
   logic [SQRT_STEPS-1:0] c_root;
   logic [31:0]           p4_c_ff    [ALIGN_LAT];
   side_c_type            p4_side_ff [DIV_STEPS];

   for (genvar g = 0; g < 3; g++) begin : g_norm
      cfsf_div u_div_nrm (
         .clock (clock),
         .en    (en),
         .numer (c_num_ff[g]),
         .denom (c_den_ff),
         .quot  (nrm_quot[g])
      );
   end

   cfsf_sqrt u_sqrt_damp (
      .clock    (clock),
      .en       (en),
      .radicand (c_mdf_ff),
      .root     (c_root)
   );

   // ---------------- stage D: velocity projections, spring term ----------------
   side_c_type         d_sc;
   logic signed [31:0] d_nrm      [3];
   logic signed [63:0] d_prod_ff  [3];
   logic signed [63:0] d_prod_in  [3];
   logic [47:0]        d_spring_ff, d_spring_in;
   logic [31:0]        d_c_ff, d_c_in;
   side_d_type         d_side_ff, d_side_in;

   always_comb begin
      d_sc = p4_side_ff[DIV_STEPS-1];
      for (int k = 0; k < 3; k++) begin
         d_side_in.nrm_mag[k] = nrm_quot[k][30:0];
         d_nrm[k] = d_sc.rp_neg[k] ? $signed(32'd0 - {1'b0, nrm_quot[k][30:0]})
                                   : $signed({1'b0, nrm_quot[k][30:0]});
         d_prod_in[k] = $signed(d_sc.rv[k]) * d_nrm[k];
      end
      d_spring_in       = 48'((64'(spring_ff) * 64'(d_sc.overlap)) >> 16);
      d_c_in            = p4_c_ff[ALIGN_LAT-1];
      d_side_in.mi      = d_sc.mi;
      d_side_in.mj      = d_sc.mj;
      d_side_in.contact = d_sc.contact;
      d_side_in.live    = d_sc.live;
      d_side_in.rp_neg  = d_sc.rp_neg;
   end

   // ---------------- stage E: normal speed ----------------
   logic signed [63:0] e_dot;
   logic [63:0]        e_dmag;
   logic [33:0]        e_av_ff, e_av_in;
   logic               e_vneg_ff, e_vneg_in;
   logic [47:0]        e_spring_ff;
   logic [31:0]        e_c_ff;
   side_d_type         e_side_ff;

   always_comb begin
      e_dot     = d_prod_ff[0] + d_prod_ff[1] + d_prod_ff[2];
      e_vneg_in = e_dot[63];
      e_dmag    = e_dot[63] ? (64'd0 - e_dot) : e_dot;
      // truncation toward zero: shift the magnitude
      e_av_in   = e_dmag[63:30];
   end

   // ---------------- stage F: damping term products ----------------
   logic [49:0] f_dmh_ff, f_dmh_in;
   logic [31:0] f_dml_ff, f_dml_in;
   logic        f_vneg_ff;
   logic [47:0] f_spring_ff;
   side_d_type  f_side_ff;

   always_comb begin
      f_dmh_in = 50'(64'(e_c_ff) * 64'(e_av_ff[33:16]));
      f_dml_in = 32'((48'(e_c_ff) * 48'(e_av_ff[15:0])) >> 16);
   end

   // ---------------- stage G: net force, saturation checks ----------------
   logic [50:0]          g_dm;
   logic [52:0]          g_fval;
   logic [52:0]          g_fmag;
   logic [50:0]          g_f_ff, g_f_in;
   logic [DIV_DEN_W-1:0] g_deni_ff, g_deni_in;
   logic [DIV_DEN_W-1:0] g_denj_ff, g_denj_in;
   side_g_type           g_side_ff, g_side_in;

   always_comb begin
      g_dm   = 51'(f_dmh_ff) + 51'(f_dml_ff);
      g_fval = f_vneg_ff ? (53'(f_spring_ff) + 53'(g_dm)) : (53'(f_spring_ff) - 53'(g_dm));
      g_fmag = g_fval[52] ? (53'd0 - g_fval) : g_fval;
      g_f_in = g_fmag[50:0];
      g_deni_in = {1'b0, f_side_ff.mi[31:1], f_side_ff.mi[0] | (f_side_ff.mi == '0)};
      g_denj_in = {1'b0, f_side_ff.mj[31:1], f_side_ff.mj[0] | (f_side_ff.mj == '0)};
      g_side_in.contact = f_side_ff.contact;
      g_side_in.live    = f_side_ff.live;
      g_side_in.nrm_mag = f_side_ff.nrm_mag;
      g_side_in.rp_neg  = f_side_ff.rp_neg;
      g_side_in.f_neg   = g_fval[52];
      // quotient would reach 2^34: clamp (covers a zero mass too)
      g_side_in.sat_i   = (g_f_in != '0) && (g_f_in >= {1'b0, f_side_ff.mi, 18'd0});
      g_side_in.sat_j   = (g_f_in != '0) && (g_f_in >= {1'b0, f_side_ff.mj, 18'd0});
   end

   // ---------------- section 6: scalar accelerations ----------------
   logic [DIV_STEPS-1:0] ai_quot;
   logic [DIV_STEPS-1:0] aj_quot;
   side_g_type           p6_side_ff [DIV_STEPS];

   cfsf_div u_div_ai (
      .clock (clock),
      .en    (en),
      .numer ({g_f_ff, 16'd0}),
      .denom (g_deni_ff),
      .quot  (ai_quot)
   );

   cfsf_div u_div_aj (
      .clock (clock),
      .en    (en),
      .numer ({g_f_ff, 16'd0}),
      .denom (g_denj_ff),
      .quot  (aj_quot)
   );

   // ---------------- stage H: project onto the normal ----------------
   side_g_type  h_sg;
   logic [33:0] h_ai;
   logic [33:0] h_aj;
   logic [63:0] h_pi_ff [3];
   logic [63:0] h_pi_in [3];
   logic [63:0] h_pj_ff [3];
   logic [63:0] h_pj_in [3];
   side_h_type  h_side_ff, h_side_in;

   always_comb begin
      h_sg = p6_side_ff[DIV_STEPS-1];
      h_ai = (h_sg.sat_i || ai_quot > ACC_CAP) ? ACC_CAP : ai_quot;
      h_aj = (h_sg.sat_j || aj_quot > ACC_CAP) ? ACC_CAP : aj_quot;
      for (int k = 0; k < 3; k++) begin
         h_pi_in[k] = 64'(h_ai[32:0]) * 64'(h_sg.nrm_mag[k]);
         h_pj_in[k] = 64'(h_aj[32:0]) * 64'(h_sg.nrm_mag[k]);
         h_side_in.neg_i[k] = h_sg.f_neg != h_sg.rp_neg[k];
      end
      h_side_in.contact = h_sg.contact;
      h_side_in.live    = h_sg.live;
   end

   // ---------------- stage I: saturate, output register ----------------
   logic [2:0][31:0] i_acc_i_ff, i_acc_i_in;
   logic [2:0][31:0] i_acc_j_ff, i_acc_j_in;
   logic             i_contact_ff, i_contact_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         i_acc_i_in[k] = h_side_ff.live ? sat_out(h_pi_ff[k][63:30], h_side_ff.neg_i[k])
                                        : 32'd0;
         i_acc_j_in[k] = h_side_ff.live ? sat_out(h_pj_ff[k][63:30], !h_side_ff.neg_i[k])
                                        : 32'd0;
      end
      i_contact_in = h_side_ff.contact;
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a_sq_ff[k]   <= a_sq_in[k];
            c_num_ff[k]  <= c_num_in[k];
            d_prod_ff[k] <= d_prod_in[k];
            h_pi_ff[k]   <= h_pi_in[k];
            h_pj_ff[k]   <= h_pj_in[k];
         end
         a_mprod_ff <= a_mprod_in;
         a_msum_ff  <= a_msum_in;
         a_side_ff  <= a_side_in;

         b_sq_ff    <= b_sq_in;
         b_mprod_ff <= b_mprod_in;
         b_mden_ff  <= b_mden_in;
         b_side_ff  <= b_side_in;

         p2_dist_ff[0] <= dist_root;
         p4_c_ff[0]    <= c_root;
         for (int s = 1; s < ALIGN_LAT; s++) begin
            p2_dist_ff[s] <= p2_dist_ff[s-1];
            p4_c_ff[s]    <= p4_c_ff[s-1];
         end
         p2_side_ff[0] <= b_side_ff;
         p4_side_ff[0] <= c_side_ff;
         p6_side_ff[0] <= g_side_ff;
         for (int s = 1; s < DIV_STEPS; s++) begin
            p2_side_ff[s] <= p2_side_ff[s-1];
            p4_side_ff[s] <= p4_side_ff[s-1];
            p6_side_ff[s] <= p6_side_ff[s-1];
         end

         c_mdf_ff  <= c_mdf_in;
         c_den_ff  <= c_den_in;
         c_side_ff <= c_side_in;

         d_spring_ff <= d_spring_in;
         d_c_ff      <= d_c_in;
         d_side_ff   <= d_side_in;

         e_av_ff     <= e_av_in;
         e_vneg_ff   <= e_vneg_in;
         e_spring_ff <= d_spring_ff;
         e_c_ff      <= d_c_ff;
         e_side_ff   <= d_side_ff;

         f_dmh_ff    <= f_dmh_in;
         f_dml_ff    <= f_dml_in;
         f_vneg_ff   <= e_vneg_ff;
         f_spring_ff <= e_spring_ff;
         f_side_ff   <= e_side_ff;

         g_f_ff    <= g_f_in;
         g_deni_ff <= g_deni_in;
         g_denj_ff <= g_denj_in;
         g_side_ff <= g_side_in;

         h_side_ff <= h_side_in;

         i_acc_i_ff   <= i_acc_i_in;
         i_acc_j_ff   <= i_acc_j_in;
         i_contact_ff <= i_contact_in;
      end
   end

   assign rsp.valid      = vld_ff[PIPE_LAT-1];
   assign rsp.accel_i_x  = $signed(i_acc_i_ff[0]);
   assign rsp.accel_i_y  = $signed(i_acc_i_ff[1]);
   assign rsp.accel_i_z  = $signed(i_acc_i_ff[2]);
   assign rsp.accel_j_x  = $signed(i_acc_j_ff[0]);
   assign rsp.accel_j_y  = $signed(i_acc_j_ff[1]);
   assign rsp.accel_j_z  = $signed(i_acc_j_ff[2]);
   assign rsp.in_contact = i_contact_ff;

   // ---------------- assertions ----------------
   `CSF_ASSERT_IMP(a_no_contact_zero, clock, reset, rsp.valid && !rsp.in_contact, rsp.accel_i_x == 32'sd0 && rsp.accel_j_y == 32'sd0 && rsp.accel_i_z == 32'sd0, "acceleration without contact")
   `CSF_ASSERT_IMP(a_opposite_x, clock, reset, rsp.valid && !rsp.accel_i_x[31] && rsp.accel_i_x != 32'sd0, rsp.accel_j_x[31] || rsp.accel_j_x == 32'sd0, "accelerations of the pair share a sign")
   `CSF_ASSERT_NXT(a_stall_hold, clock, reset, !en, vld_ff == $past(vld_ff), "pipeline moved during a stall")

endmodule

@@ rtl/cfsf_sqrt.sv @@
// Pipelined floor square root, one root bit per stage.
// Depends on cfsf_pkg.
module cfsf_sqrt
   import cfsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic [SQRT_IN_W-1:0]  radicand,
   output logic [SQRT_STEPS-1:0] root
);

   logic [SQRT_REM_W-1:0] rem_ff  [SQRT_STEPS];
   logic [SQRT_REM_W-1:0] rem_in  [SQRT_STEPS];
   logic [SQRT_STEPS-1:0] root_ff [SQRT_STEPS];
   logic [SQRT_STEPS-1:0] root_in [SQRT_STEPS];
   logic [SQRT_IN_W-1:0]  bits_ff [SQRT_STEPS];
   logic [SQRT_IN_W-1:0]  bits_in [SQRT_STEPS];

   always_comb begin
      logic [SQRT_REM_W-1:0] rem_prev;
      logic [SQRT_STEPS-1:0] root_prev;
      logic [SQRT_IN_W-1:0]  bits_prev;
      logic [SQRT_REM_W-1:0] shifted;
      logic [SQRT_REM_W-1:0] trial;
      for (int s = 0; s < SQRT_STEPS; s++) begin
         if (s == 0) begin
            rem_prev  = '0;
            root_prev = '0;
            bits_prev = radicand;
         end else begin
            rem_prev  = rem_ff[s-1];
            root_prev = root_ff[s-1];
            bits_prev = bits_ff[s-1];
         end
         shifted = {rem_prev[SQRT_REM_W-3:0], bits_prev[SQRT_IN_W-1 -: 2]};
         trial   = {1'b0, root_prev, 2'b01};
         if (shifted >= trial) begin
            rem_in[s]  = shifted - trial;
            root_in[s] = {root_prev[SQRT_STEPS-2:0], 1'b1};
         end else begin
            rem_in[s]  = shifted;
            root_in[s] = {root_prev[SQRT_STEPS-2:0], 1'b0};
         end
         bits_in[s] = {bits_prev[SQRT_IN_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQRT_STEPS; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            bits_ff[s] <= bits_in[s];
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

@@ rtl/cfsf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cfsf_pkg. Needs numer < denom * 2^DIV_STEPS and denom != 0.
module cfsf_div
   import cfsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [DIV_NUM_W-1:0] numer,
   input  logic [DIV_DEN_W-1:0] denom,
   output logic [DIV_STEPS-1:0] quot
);

   logic [DIV_REM_W-1:0] rem_ff [DIV_STEPS];
   logic [DIV_REM_W-1:0] rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] low_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] low_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_in [DIV_STEPS];
   logic [DIV_DEN_W-1:0] den_ff [DIV_STEPS];
   logic [DIV_DEN_W-1:0] den_in [DIV_STEPS];

   always_comb begin
      logic [DIV_REM_W-1:0] rem_prev;
      logic [DIV_STEPS-1:0] low_prev;
      logic [DIV_STEPS-1:0] quo_prev;
      logic [DIV_DEN_W-1:0] den_prev;
      logic [DIV_REM_W-1:0] trial;
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (s == 0) begin
            rem_prev = {1'b0, numer[DIV_NUM_W-1:DIV_STEPS]};
            low_prev = numer[DIV_STEPS-1:0];
            quo_prev = '0;
            den_prev = denom;
         end else begin
            rem_prev = rem_ff[s-1];
            low_prev = low_ff[s-1];
            quo_prev = quo_ff[s-1];
            den_prev = den_ff[s-1];
         end
         // partial remainder stays below the divisor, so its top bit is clear
         trial = {rem_prev[DIV_REM_W-2:0], low_prev[DIV_STEPS-1]};
         if (trial >= {1'b0, den_prev}) begin
            rem_in[s] = trial - {1'b0, den_prev};
            quo_in[s] = {quo_prev[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in[s] = trial;
            quo_in[s] = {quo_prev[DIV_STEPS-2:0], 1'b0};
         end
         low_in[s] = {low_prev[DIV_STEPS-2:0], 1'b0};
         den_in[s] = den_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_in[s];
         end
      end
   end

   assign quot = quo_ff[DIV_STEPS-1];

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the contact spring force pipeline.
// Depends on cfsf_pkg, cfsf_req_if, cfsf_rsp_if and the contact_spring_force top level.
`timescale 1ns / 100ps

module tb
   import cfsf_pkg::*;
();

   localparam int          PERIOD     = 10;
   localparam int          RESET_CYC  = 7;
   localparam int          RAND_ITEMS = 450;
   localparam int          N_PHASES   = 5;
   localparam int unsigned CYCLE_CAP  = 400000;
   localparam longint unsigned SCALAR_CAP = 64'h1_FFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] vel_x, vel_y, vel_z;
      logic        [31:0] m_i, m_j;
      logic        [30:0] r_i, r_j;
   } pair_type;

   typedef struct packed {
      logic signed [31:0] ai_x, ai_y, ai_z;
      logic signed [31:0] aj_x, aj_y, aj_z;
      logic               contact;
   } accel_type;

   typedef struct {
      pair_type  pair;
      bit        typed;
      accel_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SPRING_CONSTANT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfsf_req_if req ();
   cfsf_rsp_if rsp ();

   contact_spring_force u_top (
      .clock    (clock),
      .reset    (reset),
      .req      (req.sink),
      .rsp      (rsp.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   logic [31:0] spring_k  = SPRING_RESET;
   logic [31:0] damping_d = DAMPING_RESET;
   accel_type   accel_q[$];
   int          errors     = 0;
   int          n_sent     = 0;
   int          n_checked  = 0;
   int          n_contacts = 0;
   int          idle_pct   = 0;
   int          stall_pct  = 0;
   int unsigned cycles     = 0;

   // ---------------------------------------------------------------- predictor
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bt  = 64'h4000_0000_0000_0000;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned abs64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // floor(force*2^16/mass) with the cap applied before projection
   function automatic longint unsigned mass_accel(longint unsigned fmag, longint unsigned m);
      longint unsigned q1, rem, a;
      if (fmag == 0) return 0;
      if (m == 0) return SCALAR_CAP;
      q1 = fmag / m;
      if (q1 >= 64'h2_0000) return SCALAR_CAP;
      rem = fmag % m;
      a   = (q1 << 16) + ((rem << 16) / m);
      return a > SCALAR_CAP ? SCALAR_CAP : a;
   endfunction

   function automatic logic [31:0] clamp_q16(longint unsigned mag, bit neg);
      if (neg) begin
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         return 32'(-mag);
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return 32'(mag);
   endfunction

   function automatic accel_type contact_accel(pair_type p);
      accel_type       r = '0;
      longint          pos[3], vel[3], nrm[3];
      longint          dot = 0, vn, f;
      longint unsigned sq = 0, gap, mi, mj, msum, mij, c, spr, av, dm, fmag, a_i, a_j, q, nm;
      bit              ni;
      logic [31:0]     oi[3], oj[3];
      pos = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
      vel = '{longint'(p.vel_x), longint'(p.vel_y), longint'(p.vel_z)};
      for (int k = 0; k < 3; k++) sq += abs64(pos[k]) * abs64(pos[k]);
      gap = root_floor(sq);
      if (64'(p.r_i) + 64'(p.r_j) <= gap) return r;
      r.contact = 1'b1;
      if (gap == 0) return r;
      for (int k = 0; k < 3; k++) begin
         q      = (abs64(pos[k]) << 30) / gap;
         nrm[k] = pos[k] < 0 ? -longint'(q) : longint'(q);
         dot   += vel[k] * nrm[k];
      end
      vn   = dot / (64'sd1 << 30);
      mi   = 64'(p.m_i);
      mj   = 64'(p.m_j);
      msum = mi + mj;
      mij  = msum == 0 ? 0 : (mi * mj) / msum;
      c    = root_floor(mij * 64'(damping_d));
      spr  = (64'(spring_k) * (64'(p.r_i) + 64'(p.r_j) - gap)) >> 16;
      av   = abs64(vn);
      dm   = c * (av >> 16) + ((c * (av & 64'hFFFF)) >> 16);
      f    = longint'(spr) - (vn < 0 ? -longint'(dm) : longint'(dm));
      fmag = abs64(f);
      a_i  = mass_accel(fmag, mi);
      a_j  = mass_accel(fmag, mj);
      for (int k = 0; k < 3; k++) begin
         nm    = abs64(nrm[k]);
         ni    = (f < 0) != (nrm[k] < 0);
         oi[k] = clamp_q16((a_i * nm) >> 30, ni);
         oj[k] = clamp_q16((a_j * nm) >> 30, !ni);
      end
      r.ai_x = oi[0]; r.ai_y = oi[1]; r.ai_z = oi[2];
      r.aj_x = oj[0]; r.aj_y = oj[1]; r.aj_z = oj[2];
      return r;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH t=%0t result %0d %s: got %h want %h", $time, n_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (accel_q.size() == 0) begin
            report("transfer with nothing outstanding", 32'd0, 32'd0);
         end else begin
            accel_type w;
            w = accel_q.pop_front();
            if (rsp.accel_i_x !== w.ai_x) report("accel_i_x", rsp.accel_i_x, w.ai_x);
            if (rsp.accel_i_y !== w.ai_y) report("accel_i_y", rsp.accel_i_y, w.ai_y);
            if (rsp.accel_i_z !== w.ai_z) report("accel_i_z", rsp.accel_i_z, w.ai_z);
            if (rsp.accel_j_x !== w.aj_x) report("accel_j_x", rsp.accel_j_x, w.aj_x);
            if (rsp.accel_j_y !== w.aj_y) report("accel_j_y", rsp.accel_j_y, w.aj_y);
            if (rsp.accel_j_z !== w.aj_z) report("accel_j_z", rsp.accel_j_z, w.aj_z);
            if (rsp.in_contact !== w.contact)
               report("in_contact", 32'(rsp.in_contact), 32'(w.contact));
            n_checked++;
         end
      end
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, accel_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic send_pair(pair_type p, bit typed, accel_type want);
      accel_type pred;
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.rel_pos_x <= p.pos_x; req.rel_pos_y <= p.pos_y; req.rel_pos_z <= p.pos_z;
      req.rel_vel_x <= p.vel_x; req.rel_vel_y <= p.vel_y; req.rel_vel_z <= p.vel_z;
      req.mass_i    <= p.m_i;   req.mass_j    <= p.m_j;
      req.radius_i  <= p.r_i;   req.radius_j  <= p.r_j;
      do @(posedge clock); while (!req.ready);
      pred = contact_accel(p);
      if (typed && pred !== want)
         $display("note: typed expectation differs from prediction, row %0d", n_sent);
      accel_q.push_back(typed ? want : pred);
      if (pred.contact) n_contacts++;
      n_sent++;
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      while (accel_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_SPRING_CONSTANT) spring_k = data;
      else damping_d = data;
      @(posedge clock);
   endtask

   function automatic logic [31:0] wide_rand();
      case ($urandom_range(3))
         0: return $urandom_range(255);
         1: return $urandom;
         2: return 32'($urandom_range(32'h0010_0000));
         default: return {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
      endcase
   endfunction

   // mostly touching pairs with random content, the rest unconstrained
   function automatic pair_type random_pair();
      pair_type p;
      int       span;
      int       sel;
      sel = $urandom_range(99);
      p.m_i = $urandom_range(3) == 0 ? wide_rand() : 32'($urandom_range(32'h0040_0000, 1));
      p.m_j = $urandom_range(3) == 0 ? wide_rand() : 32'($urandom_range(32'h0040_0000, 1));
      if (p.m_i == 0) p.m_i = 1;
      if (p.m_j == 0) p.m_j = 1;
      p.vel_x = wide_rand(); p.vel_y = wide_rand(); p.vel_z = wide_rand();
      if (sel < 70) begin
         span  = $urandom_range(1) ? 'h2_0000 : 'h1000_0000;
         p.r_i = 31'($urandom_range(span, 1));
         p.r_j = 31'($urandom_range(span, 1));
         span  = (int'(p.r_i) + int'(p.r_j)) / 2;
         p.pos_x = $signed(32'($urandom_range(2 * span))) - span;
         p.pos_y = $signed(32'($urandom_range(2 * span))) - span;
         p.pos_z = $signed(32'($urandom_range(2 * span))) - span;
         if ($urandom_range(3) == 0) begin
            p.vel_x = $signed(32'($urandom_range(16'hFFFF))) - 16'h8000;
            p.vel_y = $signed(32'($urandom_range(16'hFFFF))) - 16'h8000;
            p.vel_z = $signed(32'($urandom_range(16'hFFFF))) - 16'h8000;
         end
      end else begin
         p.r_i = 31'($urandom);
         p.r_j = 31'($urandom);
         if (p.r_i == 0) p.r_i = 1;
         if (p.r_j == 0) p.r_j = 1;
         p.pos_x = wide_rand(); p.pos_y = wide_rand(); p.pos_z = wide_rand();
      end
      return p;
   endfunction

   stim_row_type directed[$];

   function automatic pair_type mk(int px, int py, int pz, int vx, int vy, int vz,
                                   logic [31:0] mi, logic [31:0] mj,
                                   logic [30:0] ri, logic [30:0] rj);
      pair_type p;
      p.pos_x = px; p.pos_y = py; p.pos_z = pz;
      p.vel_x = vx; p.vel_y = vy; p.vel_z = vz;
      p.m_i = mi; p.m_j = mj; p.r_i = ri; p.r_j = rj;
      return p;
   endfunction

   task automatic add_row(pair_type p, bit typed, logic contact);
      stim_row_type row;
      row.pair  = p;
      row.typed = typed;
      row.want  = '0;
      row.want.contact = contact;
      directed.push_back(row);
   endtask

   initial begin
      int    per_phase;
      int    phase_idle[N_PHASES]  = '{0, 80, 0, 33, 0};
      int    phase_stall[N_PHASES] = '{0, 0, 80, 33, 0};
      logic [31:0] cfg_k[N_PHASES] = '{SPRING_RESET, 32'h0, 32'hFFFF_FFFF, 32'h0000_4000,
                                       32'h0};
      logic [31:0] cfg_d[N_PHASES] = '{DAMPING_RESET, 32'h0, 32'hFFFF_FFFF, 32'h0003_0000,
                                       32'h0};
      cfg_k[4] = $urandom;
      cfg_d[4] = $urandom;
      req.valid <= 1'b0;
      {req.rel_pos_x, req.rel_pos_y, req.rel_pos_z} <= '0;
      {req.rel_vel_x, req.rel_vel_y, req.rel_vel_z} <= '0;
      {req.mass_i, req.mass_j, req.radius_i, req.radius_j} <= '0;

      // apart, touching exactly, coincident centres, extremes
      add_row(mk('h3_0000, 0, 0, 0, 0, 0, 'h1_0000, 'h1_0000, 'h1_0000, 'h1_0000), 1, 0);
      add_row(mk('h2_0000, 0, 0, 5, 5, 5, 'h1_0000, 'h1_0000, 'h1_0000, 'h1_0000), 1, 0);
      add_row(mk(0, 0, 0, 'h7FFF_FFFF, 0, -1, 'h1_0000, 'h2_0000, 1, 1), 1, 1);
      add_row(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1), 1, 0);
      add_row(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1, 1, 1, 1), 1, 0);
      add_row(mk('h1_0000, 0, 0, 0, 0, 0, 'h1_0000, 'h1_0000, 'h1_0000, 'h1_0000), 0, 0);
      add_row(mk(0, -'h1_0000, 0, 'h1_0000, -'h2_0000, 0, 'h1_0000, 'h4_0000,
                 'h1_0000, 'h8000), 0, 0);
      add_row(mk(1, 1, 1, 0, 0, 0, 1, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, 0);
      add_row(mk(-1, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, 0);
      add_row(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                 32'hFFFF_FFFF, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, 0);
      add_row(mk('h100, 'h100, -'h100, -'h7FFF_FFFF, 0, 0, 1, 1, 'h1000, 'h1000), 0, 0);
      add_row(mk('h8000, 0, 0, 'h7FFF_FFFF, 0, 0, 'h10, 'h10, 'h1_0000, 'h1_0000), 0, 0);

      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[n]) send_pair(directed[n].pair, directed[n].typed, directed[n].want);

      per_phase = RAND_ITEMS / N_PHASES;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain();
         write_reg(CSR_SPRING_CONSTANT, cfg_k[ph]);
         write_reg(CSR_DAMPING_FACTOR, cfg_d[ph]);
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         repeat (per_phase) send_pair(random_pair(), 0, '0);
      end
      drain();
      repeat (PIPE_LAT + 20) @(posedge clock);

      $display("Sent %0d pairs (%0d in contact) over %0d register settings and idle mixes;",
               n_sent, n_contacts, N_PHASES);
      $display("checked %0d results in %0d cycles, %0d mismatches.", n_checked, cycles, errors);
      if (errors == 0 && accel_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cfsf_pkg.sv
rtl/cfsf_req_if.sv
rtl/cfsf_rsp_if.sv
rtl/cfsf_sqrt.sv
rtl/cfsf_div.sv
rtl/contact_spring_force.sv
tb/tb.sv
